// ===== hw/rtl/slsfr_pkg.sv =====
`default_nettype none

package slsfr_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned HEADER_BYTES = 2;

   localparam logic [BYTE_W-1:0] START_RESET = 8'h7F;
   localparam logic [BYTE_W-1:0] MIN_BODY    = 8'd2;

   typedef enum logic [1:0] {
      PH_FIRST  = 2'd0,
      PH_LENGTH = 2'(HEADER_BYTES - 1),
      PH_BODY   = 2'(HEADER_BYTES)
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_BODY      = 3'd0,
      ST_GOOD      = 3'd1,
      ST_BAD_START = 3'd2,
      ST_BAD_SUM   = 3'd3,
      ST_SHORT     = 3'd4
   } status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sof_length_sum_frame_receiver_top.sv =====
// Path: an accepted byte is held in the input register, then moves to the response register.
// Throughput: one byte per cycle while rsp_ready drains the response register, set by the input register feeding it.
// The start byte and a good length byte produce no response transaction; a header error
// produces one at the length byte.
// Reset (synchronous, active high) clears both stages, the frame state and sets the
// start value to 0x7F; no clearing pass is needed.
`default_nettype none

module sof_length_sum_frame_receiver_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request channel: one received byte per transaction
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [slsfr_pkg::BYTE_W-1:0]    req_rx_byte,
   // response channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [slsfr_pkg::BYTE_W-1:0]         rsp_data_byte,
   output logic [slsfr_pkg::BYTE_W-1:0]         rsp_position,
   output logic                                 rsp_last,
   output logic [slsfr_pkg::STATUS_W-1:0]       rsp_status,
   output logic [slsfr_pkg::BYTE_W-1:0]         rsp_payload_length,
   // configuration write channel: start-of-frame byte value
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [slsfr_pkg::BYTE_W-1:0]    csr_start_value
);

   // configuration register
   logic [slsfr_pkg::BYTE_W-1:0] start_value_ff;

   // input stage: holds the accepted byte until the response stage can take it
   logic                         in_valid_ff;
   logic [slsfr_pkg::BYTE_W-1:0] in_byte_ff;

   // frame state
   slsfr_pkg::phase_type         phase_ff, phase_in;
   logic                         start_matched_ff, start_matched_in;
   logic [slsfr_pkg::BYTE_W-1:0] body_length_ff, body_length_in;
   logic [slsfr_pkg::BYTE_W-1:0] byte_count_ff, byte_count_in;
   logic [slsfr_pkg::BYTE_W-1:0] running_sum_ff, running_sum_in;

   // response stage
   logic                         rsp_valid_ff;
   logic [slsfr_pkg::BYTE_W-1:0] data_byte_ff, data_byte_in;
   logic [slsfr_pkg::BYTE_W-1:0] position_ff, position_in;
   logic                         last_ff, last_in;
   slsfr_pkg::status_type        status_ff, status_in;
   logic [slsfr_pkg::BYTE_W-1:0] payload_length_ff, payload_length_in;
   logic                         emit_in;

   logic                         advance;
   logic [slsfr_pkg::BYTE_W-1:0] sum_next;
   logic [slsfr_pkg::BYTE_W-1:0] count_next;

   // Advance the held byte whenever the response register is free or being drained.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign sum_next   = running_sum_ff + in_byte_ff;
   assign count_next = byte_count_ff + 8'd1;

   // Next frame state for the byte in the input stage.
   always_comb begin
      phase_in         = phase_ff;
      start_matched_in = start_matched_ff;
      body_length_in   = body_length_ff;
      byte_count_in    = byte_count_ff;
      running_sum_in   = running_sum_ff;
      unique case (phase_ff)
         slsfr_pkg::PH_LENGTH: begin
            phase_in = slsfr_pkg::PH_FIRST;
            // enter the body only for a matched start and a usable length
            if (start_matched_ff && (in_byte_ff >= slsfr_pkg::MIN_BODY)) begin
               phase_in       = slsfr_pkg::PH_BODY;
               body_length_in = in_byte_ff;
               byte_count_in  = '0;
               running_sum_in = '0;
            end
         end
         slsfr_pkg::PH_BODY: begin
            running_sum_in = sum_next;
            byte_count_in  = count_next;
            if (count_next == body_length_ff) begin
               phase_in = slsfr_pkg::PH_FIRST;
            end
         end
         default: begin
            // first header byte; the unused phase code lands here too
            start_matched_in = (in_byte_ff == start_value_ff);
            phase_in         = slsfr_pkg::PH_LENGTH;
         end
      endcase
   end

   // Response fields for the byte in the input stage.
   always_comb begin
      emit_in           = 1'b0;
      data_byte_in      = '0;
      position_in       = '0;
      last_in           = 1'b0;
      status_in         = slsfr_pkg::ST_BODY;
      payload_length_in = '0;
      unique case (phase_ff)
         slsfr_pkg::PH_LENGTH: begin
            // drop the length byte; report header errors
            if (!start_matched_ff) begin
               emit_in   = 1'b1;
               last_in   = 1'b1;
               status_in = slsfr_pkg::ST_BAD_START;
            end else if (in_byte_ff < slsfr_pkg::MIN_BODY) begin
               emit_in   = 1'b1;
               last_in   = 1'b1;
               status_in = slsfr_pkg::ST_SHORT;
            end
         end
         slsfr_pkg::PH_BODY: begin
            emit_in      = 1'b1;
            data_byte_in = in_byte_ff;
            position_in  = byte_count_ff;
            if (count_next == body_length_ff) begin
               last_in = 1'b1;
               if (sum_next == '0) begin
                  status_in         = slsfr_pkg::ST_GOOD;
                  payload_length_in = body_length_ff - slsfr_pkg::MIN_BODY;
               end else begin
                  status_in = slsfr_pkg::ST_BAD_SUM;
               end
            end
         end
         default: begin
            emit_in = 1'b0;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff   <= slsfr_pkg::START_RESET;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         phase_ff         <= slsfr_pkg::PH_FIRST;
         start_matched_ff <= 1'b0;
         body_length_ff   <= '0;
         byte_count_ff    <= '0;
         running_sum_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            start_value_ff <= csr_start_value;
         end
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff     <= emit_in;
            phase_ff         <= phase_in;
            start_matched_ff <= start_matched_in;
            body_length_ff   <= body_length_in;
            byte_count_ff    <= byte_count_in;
            running_sum_ff   <= running_sum_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         data_byte_ff      <= data_byte_in;
         position_ff       <= position_in;
         last_ff           <= last_in;
         status_ff         <= status_in;
         payload_length_ff <= payload_length_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_byte      = data_byte_ff;
   assign rsp_position       = position_ff;
   assign rsp_last           = last_ff;
   assign rsp_status         = status_ff;
   assign rsp_payload_length = payload_length_ff;

endmodule

`default_nettype wire
